@@ src/pnht_pkg.sv @@
// Shared types and codes for the procedure name hash table.
`timescale 1ns / 1ps

package pnht_pkg;

    localparam int HASH_W     = 32;
    localparam int HASH_SHIFT = 29;

    typedef enum logic [1:0]
    {
        CMD_KEY    = 2'd0,
        CMD_CREATE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0]
    {
        RES_OK        = 3'd0,
        RES_NOT_FOUND = 3'd1,
        RES_OWNED     = 3'd2,
        RES_FULL      = 3'd3,
        RES_BAD_KEY   = 3'd4
    } res_code_t;

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_HOME,
        ST_PRB_RD,
        ST_PRB_EV,
        ST_RM_RD,
        ST_RM_EV,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic      key_take;
        logic      key_clear;
        logic      latch;
        logic      mod_start;
        logic      mod_step;
        logic      pos_zero;
        logic      pos_inc;
        logic      pos_home;
        logic      pos_stride;
        logic      mem_rd;
        logic      eval;
        logic      meta_clr;
        logic      wr_entry;
        logic      wr_free;
        logic      rsp_load;
        res_code_t res;
        logic      found;
    } dp_cmd_t;

    typedef struct packed
    {
        logic bad_key;
        logic mod_last;
        logic hit;
        logic owner_eq;
        logic free_any;
        logic wrap;
        logic sweep_last;
        logic rm_match;
        logic rsp_busy;
        logic rsp_valid;
    } dp_stat_t;

endpackage

@@ src/pnht_dp.sv @@
// Datapath: key buffer, hash, modulo unit, probe pointer, slot memories, result word.
`timescale 1ns / 1ps

module pnht_dp #(
    parameter int TABLE_SLOTS    = 1013,
    parameter int MAX_NAME_BYTES = 31,
    parameter int PROBE_STRIDE   = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         key_byte,
    input  logic [15:0]        program_id,
    input  logic signed [31:0] entry_address,
    input  logic [7:0]         arg_count,
    input  pnht_pkg::dp_cmd_t  ctl,
    output pnht_pkg::dp_stat_t stat,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [2:0]         status,
    output logic [15:0]        found_program,
    output logic signed [31:0] found_address,
    output logic [7:0]         found_arg_count
);
    import pnht_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int STEP   = PROBE_STRIDE % TABLE_SLOTS;
    localparam int IDX_W  = $clog2(MAX_NAME_BYTES);
    localparam int LEN_W  = $clog2(MAX_NAME_BYTES + 1);
    localparam int NAME_W = MAX_NAME_BYTES * 8;
    localparam logic [SLOT_W:0] SLOTS_X = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [SLOT_W:0] STEP_X  = (SLOT_W + 1)'(STEP);
    localparam logic [SLOT_W:0] LAST_X  = (SLOT_W + 1)'(TABLE_SLOTS - 1);
    localparam logic [HASH_W-1:0] FOLD_K = HASH_W'((1 << SLOT_W) - TABLE_SLOTS);
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_Z = 8'h5A;

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_A && b <= CH_Z)
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

    // key state
    logic [7:0]        kbuf_reg [MAX_NAME_BYTES];
    logic [LEN_W-1:0]  key_len_reg, key_len_next;
    logic              overlong_reg, overlong_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [NAME_W-1:0] key_vec;
    logic [7:0]        lb;

    // modulo unit
    logic [HASH_W-1:0] sh_reg, sh_next;
    logic [SLOT_W:0]   rem_lo, rem_red;

    // probe pointer
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [SLOT_W-1:0] home_reg, home_next;
    logic [SLOT_W-1:0] free_reg, free_next;
    logic              free_seen_reg, free_seen_next;
    logic [SLOT_W:0]   pos_sum, pos_step;

    // request payload
    logic [15:0]        pid_reg;
    logic signed [31:0] addr_reg;
    logic [7:0]         args_reg;

    // slot memories
    logic [16:0]        meta_mem [TABLE_SLOTS];
    logic [NAME_W-1:0]  name_mem [TABLE_SLOTS];
    logic signed [31:0] addr_mem [TABLE_SLOTS];
    logic [7:0]         args_mem [TABLE_SLOTS];
    logic [16:0]        rd_meta_reg;
    logic [NAME_W-1:0]  rd_name_reg;
    logic signed [31:0] rd_addr_reg;
    logic [7:0]         rd_args_reg;
    logic [SLOT_W-1:0]  wa;
    logic               meta_we;
    logic [16:0]        meta_wd;

    // result word
    logic               rsp_valid_reg, rsp_valid_next;
    logic [2:0]         status_reg;
    logic [15:0]        fprog_reg;
    logic signed [31:0] faddr_reg;
    logic [7:0]         fargs_reg;

    assign lb = to_lower(key_byte);

    for (genvar i = 0; i < MAX_NAME_BYTES; i++)
    begin : g_key
        assign key_vec[i*8 +: 8] = (LEN_W'(i) < key_len_reg) ? kbuf_reg[i] : 8'h00;
    end

    always_comb
    begin
        key_len_next  = key_len_reg;
        overlong_next = overlong_reg;
        hash_next     = hash_reg;
        if (ctl.key_clear)
        begin
            key_len_next  = '0;
            overlong_next = 1'b0;
            hash_next     = '0;
        end
        else if (ctl.key_take && key_byte != 8'h00)
        begin
            hash_next = (hash_reg << 3) + hash_reg + (hash_reg >> HASH_SHIFT)
                        + HASH_W'(lb);
            if (key_len_reg < LEN_W'(MAX_NAME_BYTES))
            begin
                key_len_next = key_len_reg + LEN_W'(1);
            end
            else
            begin
                overlong_next = 1'b1;
            end
        end
    end

    // names are kept lowercased; only compared, never returned
    always_ff @(posedge clk)
    begin
        if (ctl.key_take && key_byte != 8'h00 && key_len_reg < LEN_W'(MAX_NAME_BYTES))
        begin
            kbuf_reg[key_len_reg[IDX_W-1:0]] <= lb;
        end
    end

    // fold the bits above the slot index back in with weight 2^SLOT_W mod TABLE_SLOTS
    // until none are left, then one compare and subtract
    assign rem_lo  = {1'b0, sh_reg[SLOT_W-1:0]};
    assign rem_red = (rem_lo >= SLOTS_X) ? rem_lo - SLOTS_X : rem_lo;

    always_comb
    begin
        sh_next = sh_reg;
        if (ctl.mod_start)
        begin
            sh_next = hash_reg;
        end
        else if (ctl.mod_step)
        begin
            sh_next = HASH_W'(sh_reg[HASH_W-1:SLOT_W]) * FOLD_K
                      + HASH_W'(sh_reg[SLOT_W-1:0]);
        end
    end

    assign pos_sum  = {1'b0, pos_reg} + STEP_X;
    assign pos_step = (pos_sum >= SLOTS_X) ? pos_sum - SLOTS_X : pos_sum;

    always_comb
    begin
        pos_next       = pos_reg;
        home_next      = home_reg;
        free_next      = free_reg;
        free_seen_next = free_seen_reg;
        if (ctl.pos_zero)
        begin
            pos_next = '0;
        end
        else if (ctl.pos_inc)
        begin
            pos_next = pos_reg + SLOT_W'(1);
        end
        else if (ctl.pos_home)
        begin
            pos_next       = rem_red[SLOT_W-1:0];
            home_next      = rem_red[SLOT_W-1:0];
            free_seen_next = 1'b0;
        end
        else if (ctl.pos_stride)
        begin
            pos_next = pos_step[SLOT_W-1:0];
        end
        if (ctl.eval && !free_seen_reg && !rd_meta_reg[16])
        begin
            free_next      = pos_reg;
            free_seen_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg   <= '0;
            overlong_reg  <= 1'b0;
            hash_reg      <= '0;
            pos_reg       <= '0;
            free_seen_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            key_len_reg   <= key_len_next;
            overlong_reg  <= overlong_next;
            hash_reg      <= hash_next;
            pos_reg       <= pos_next;
            free_seen_reg <= free_seen_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        home_reg <= home_next;
        free_reg <= free_next;
        if (ctl.latch)
        begin
            pid_reg  <= program_id;
            addr_reg <= entry_address;
            args_reg <= arg_count;
        end
    end

    assign wa      = ctl.wr_free ? free_reg : pos_reg;
    assign meta_we = ctl.meta_clr || ctl.wr_entry;
    assign meta_wd = ctl.wr_entry ? {1'b1, pid_reg} : 17'd0;

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[wa] <= meta_wd;
        end
        if (ctl.mem_rd)
        begin
            rd_meta_reg <= meta_mem[pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_entry)
        begin
            name_mem[wa] <= key_vec;
        end
        if (ctl.mem_rd)
        begin
            rd_name_reg <= name_mem[pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_entry)
        begin
            addr_mem[wa] <= addr_reg;
        end
        if (ctl.mem_rd)
        begin
            rd_addr_reg <= addr_mem[pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_entry)
        begin
            args_mem[wa] <= args_reg;
        end
        if (ctl.mem_rd)
        begin
            rd_args_reg <= args_mem[pos_reg];
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (ctl.rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rsp_load)
        begin
            status_reg <= ctl.res;
            fprog_reg  <= ctl.found ? rd_meta_reg[15:0] : 16'd0;
            faddr_reg  <= ctl.found ? rd_addr_reg : 32'sd0;
            fargs_reg  <= ctl.found ? rd_args_reg : 8'd0;
        end
    end

    assign stat.bad_key    = (key_len_reg == '0) || overlong_reg;
    assign stat.mod_last   = (sh_reg[HASH_W-1:SLOT_W] == '0);
    assign stat.hit        = (rd_meta_reg[15:0] != 16'd0) && (rd_name_reg == key_vec);
    assign stat.owner_eq   = (rd_meta_reg[15:0] == pid_reg);
    assign stat.free_any   = free_seen_reg || !rd_meta_reg[16];
    assign stat.wrap       = (pos_step[SLOT_W-1:0] == home_reg);
    assign stat.sweep_last = ({1'b0, pos_reg} == LAST_X);
    assign stat.rm_match   = (rd_meta_reg[15:0] == pid_reg);
    assign stat.rsp_busy   = rsp_valid_reg && rsp_stall;
    assign stat.rsp_valid  = rsp_valid_reg;

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign found_program   = fprog_reg;
    assign found_address   = faddr_reg;
    assign found_arg_count = fargs_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} < SLOTS_X)
        else $error("probe pointer beyond table");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        key_len_reg <= LEN_W'(MAX_NAME_BYTES))
        else $error("key length beyond buffer");

    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_entry && ctl.wr_free |-> free_seen_reg && ({1'b0, free_reg} < SLOTS_X))
        else $error("write to free slot without a recorded free slot");

endmodule

@@ src/pnht_ctrl.sv @@
// Controller: sequences clearing, key intake, probing, removal and result hand-off.
`timescale 1ns / 1ps

module pnht_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  pnht_pkg::cmd_code_t cmd,
    input  pnht_pkg::dp_stat_t  stat,
    output pnht_pkg::dp_cmd_t   ctl
);
    import pnht_pkg::*;

    state_t    state_reg, state_next;
    cmd_code_t op_reg, op_next;
    res_code_t res_reg, res_next;
    logic      found_reg, found_next;
    logic      sel_free_reg, sel_free_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            op_reg       <= CMD_KEY;
            res_reg      <= RES_OK;
            found_reg    <= 1'b0;
            sel_free_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            res_reg      <= res_next;
            found_reg    <= found_next;
            sel_free_reg <= sel_free_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        res_next      = res_reg;
        found_next    = found_reg;
        sel_free_next = sel_free_reg;
        ctl           = '0;
        ctl.res       = res_reg;
        ctl.found     = found_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ctl.meta_clr = 1'b1;
                if (stat.sweep_last)
                begin
                    ctl.pos_zero = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    ctl.pos_inc = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = cmd;
                    found_next = 1'b0;
                    res_next   = RES_OK;
                    case (cmd)
                        CMD_KEY:
                        begin
                            ctl.key_take = 1'b1;
                        end
                        CMD_REMOVE:
                        begin
                            ctl.latch    = 1'b1;
                            ctl.pos_zero = 1'b1;
                            state_next   = ST_RM_RD;
                        end
                        default:
                        begin
                            ctl.latch = 1'b1;
                            if (stat.bad_key)
                            begin
                                res_next   = RES_BAD_KEY;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                ctl.mod_start = 1'b1;
                                state_next    = ST_MOD;
                            end
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                ctl.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = ST_HOME;
                end
            end
            ST_HOME:
            begin
                ctl.pos_home = 1'b1;
                state_next   = ST_PRB_RD;
            end
            ST_PRB_RD:
            begin
                ctl.mem_rd = 1'b1;
                state_next = ST_PRB_EV;
            end
            ST_PRB_EV:
            begin
                ctl.eval = 1'b1;
                if (stat.hit)
                begin
                    if (op_reg == CMD_LOOKUP)
                    begin
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (stat.owner_eq)
                    begin
                        sel_free_next = 1'b0;
                        state_next    = ST_WRITE;
                    end
                    else
                    begin
                        res_next   = RES_OWNED;
                        state_next = ST_DONE;
                    end
                end
                else if (stat.wrap)
                begin
                    if (op_reg == CMD_LOOKUP)
                    begin
                        res_next   = RES_NOT_FOUND;
                        state_next = ST_DONE;
                    end
                    else if (stat.free_any)
                    begin
                        sel_free_next = 1'b1;
                        state_next    = ST_WRITE;
                    end
                    else
                    begin
                        res_next   = RES_FULL;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    ctl.pos_stride = 1'b1;
                    state_next     = ST_PRB_RD;
                end
            end
            ST_RM_RD:
            begin
                ctl.mem_rd = 1'b1;
                state_next = ST_RM_EV;
            end
            ST_RM_EV:
            begin
                ctl.meta_clr = stat.rm_match;
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.pos_inc = 1'b1;
                    state_next  = ST_RM_RD;
                end
            end
            ST_WRITE:
            begin
                ctl.wr_entry = 1'b1;
                ctl.wr_free  = sel_free_reg;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!stat.rsp_busy)
                begin
                    ctl.rsp_load  = 1'b1;
                    ctl.key_clear = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && !stat.rsp_busy |=> stat.rsp_valid && state_reg == ST_IDLE)
        else $error("result word not loaded on completion");

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |-> res_reg == RES_OK && op_reg == CMD_CREATE)
        else $error("slot written by a failing or non-create command");

    a_lookup_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        op_reg == CMD_LOOKUP && state_reg != ST_IDLE && state_reg != ST_CLEAR
        |-> !ctl.wr_entry && !ctl.meta_clr)
        else $error("lookup modified the table");

endmodule

@@ src/procedure_name_hash_table.sv @@
// Procedure name hash table: open addressing with linear probing, top level.
`timescale 1ns / 1ps

// Key bytes (cmd 0) are taken one per cycle and folded into a running
// case-insensitive hash. A create or lookup then reduces the hash modulo
// TABLE_SLOTS by folding the bits above the slot index back in, one fold a
// cycle, loads the home slot and probes slot after slot (registered memory
// read, then compare) until a hit or the walk would wrap to the home slot;
// a create that writes adds a write step. A bad key answers without probing.
// A remove sweeps every slot, each by a read and then a compare. After reset
// a clearing pass over every slot runs before the first word is accepted.
// A result word waits in an output register until taken.

module procedure_name_hash_table #(
    parameter int TABLE_SLOTS    = 1013,
    parameter int MAX_NAME_BYTES = 31,
    parameter int PROBE_STRIDE   = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         cmd,
    input  logic [7:0]         key_byte,
    input  logic [15:0]        program_id,
    input  logic signed [31:0] entry_address,
    input  logic [7:0]         arg_count,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [2:0]         status,
    output logic [15:0]        found_program,
    output logic signed [31:0] found_address,
    output logic [7:0]         found_arg_count
);
    import pnht_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    pnht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd_code_t'(cmd)),
        .stat      (stat),
        .ctl       (ctl)
    );

    pnht_dp #(
        .TABLE_SLOTS    (TABLE_SLOTS),
        .MAX_NAME_BYTES (MAX_NAME_BYTES),
        .PROBE_STRIDE   (PROBE_STRIDE)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .key_byte        (key_byte),
        .program_id      (program_id),
        .entry_address   (entry_address),
        .arg_count       (arg_count),
        .ctl             (ctl),
        .stat            (stat),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .found_program   (found_program),
        .found_address   (found_address),
        .found_arg_count (found_arg_count)
    );

endmodule
